[rtl/ira_pkg.sv]
// Shared types and constants for the integer-to-ASCII converter.
// Holds the sequencer states, the digit unit command struct and the digit tables.
// No dependencies.
`default_nettype none

package ira_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Digit unit operations.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DABBLE,
    OP_SHIFT
  } op_t;

  // Digit width selection of the digit unit.
  typedef enum logic [1:0] {
    RAD_DEC,
    RAD_BIN,
    RAD_OCT,
    RAD_HEX
  } radix_t;

  typedef struct packed {
    op_t    op;
    radix_t radix;
  } unit_ctl_t;

  // Format kind codes on the kind port.
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_BIN  = 3'd2;
  localparam logic [2:0] KIND_OCT  = 3'd3;
  localparam logic [2:0] KIND_HEXL = 3'd4;
  localparam logic [2:0] KIND_HEXU = 3'd5;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [7:0] DIGITS_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  localparam logic [7:0] DIGITS_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  function automatic radix_t kind_radix(input logic [2:0] k);
    radix_t r;
    case (k)
      KIND_SDEC, KIND_UDEC: r = RAD_DEC;
      KIND_BIN:             r = RAD_BIN;
      KIND_OCT:             r = RAD_OCT;
      default:              r = RAD_HEX;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/integer_radix_to_ascii.sv]
// Top level of the integer-to-ASCII converter: sequencer, sign handling, character output.
// Depends on ira_pkg and ira_digit_unit.
`default_nettype none

// Converts one VALUE_BITS-bit operand to ASCII text, most significant digit first,
// with no leading zeros; a zero operand gives a single '0' and signed decimal puts
// '-' before the magnitude of a negative operand (the most negative value prints as
// its true magnitude). A transfer in happens at a rising edge with start high and
// busy low; kinds 6 and 7 are ignored and give no output. Each character is
// on character/last for exactly one cycle with strobe high and is not held: the
// receiver must take it then. Per operand, decimal kinds first run the
// shift-and-add-3 loop of the shared digit unit over every operand bit, then show
// '-' if negative, then one decimal digit position per cycle (10 at 32 bits),
// leading zero positions included but silent; binary, octal and hex show one digit
// position per cycle (32, 11 and 8 at 32 bits). Busy drops in the cycle that shows
// the last character, and the next operand may be taken at the edge that ends that
// cycle.
module integer_radix_to_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic [2:0]            kind,
  output logic                       busy,
  output logic                       strobe,
  output logic      [7:0]            character,
  output logic                       last
);

  // Decimal digits of the largest operand; floor(VALUE_BITS * log10(2)) + 1.
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  // The BCD word is also wide enough for the left-aligned binary, octal and hex forms.
  localparam int WORK_BITS  = 4 * DEC_DIGITS;
  localparam int CW         = $clog2(VALUE_BITS + 1);

  ira_pkg::state_t    state, state_next;
  ira_pkg::unit_ctl_t ctl;
  ira_pkg::radix_t    radix_now;

  logic [2:0]            mode;
  logic                  sign_pending;
  logic                  seen;
  logic [CW-1:0]         digits_left;
  logic [CW-1:0]         bit_count;
  logic [CW-1:0]         load_digits;
  logic                  kind_ok;
  logic                  take;
  logic                  negative;
  logic [VALUE_BITS-1:0] magnitude;
  logic [3:0]            digit;
  logic                  skip;
  logic                  strobe_next;
  logic [7:0]            character_next;
  logic                  last_next;

  assign busy    = (state != ira_pkg::ST_IDLE);
  assign kind_ok = (kind <= ira_pkg::KIND_HEXU);
  assign take    = start && !busy && kind_ok;

  // Magnitude at full operand width, so the most negative value does not overflow.
  assign negative  = (kind == ira_pkg::KIND_SDEC) && value[VALUE_BITS-1];
  assign magnitude = negative ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;

  always_comb begin
    case (ira_pkg::kind_radix(kind))
      ira_pkg::RAD_DEC: load_digits = CW'(DEC_DIGITS);
      ira_pkg::RAD_BIN: load_digits = CW'(VALUE_BITS);
      ira_pkg::RAD_OCT: load_digits = CW'(OCT_DIGITS);
      default:          load_digits = CW'(HEX_DIGITS);
    endcase
  end

  // While idle the unit is loaded for the incoming kind; afterwards follow the held mode.
  assign radix_now = busy ? ira_pkg::kind_radix(mode) : ira_pkg::kind_radix(kind);

  // Drop leading zero digits, but never the last digit position.
  assign skip = (digit == 4'd0) && !seen && (digits_left != CW'(1));

  ira_digit_unit #(
    .VALUE_BITS (VALUE_BITS),
    .WORK_BITS  (WORK_BITS)
  ) u_digit (
    .clk       (clk),
    .ctl       (ctl),
    .magnitude (magnitude),
    .digit     (digit)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ira_pkg::ST_IDLE: begin
        if (take) begin
          if (ira_pkg::kind_radix(kind) == ira_pkg::RAD_DEC) begin
            state_next = ira_pkg::ST_DABBLE;
          end else begin
            state_next = ira_pkg::ST_EMIT;
          end
        end
      end
      ira_pkg::ST_DABBLE: begin
        if (bit_count == CW'(1)) begin
          state_next = sign_pending ? ira_pkg::ST_SIGN : ira_pkg::ST_EMIT;
        end
      end
      ira_pkg::ST_SIGN: begin
        state_next = ira_pkg::ST_EMIT;
      end
      ira_pkg::ST_EMIT: begin
        if (digits_left == CW'(1)) begin
          state_next = ira_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ira_pkg::ST_IDLE;
      end
    endcase
  end

  // Unit commands and the next output character.
  always_comb begin
    ctl.op         = ira_pkg::OP_HOLD;
    ctl.radix      = radix_now;
    strobe_next    = 1'b0;
    last_next      = 1'b0;
    character_next = (mode == ira_pkg::KIND_HEXU) ? ira_pkg::DIGITS_UPPER[digit]
                                                  : ira_pkg::DIGITS_LOWER[digit];
    case (state)
      ira_pkg::ST_IDLE: begin
        if (take) begin
          ctl.op = ira_pkg::OP_LOAD;
        end
      end
      ira_pkg::ST_DABBLE: begin
        ctl.op = ira_pkg::OP_DABBLE;
      end
      ira_pkg::ST_SIGN: begin
        strobe_next    = 1'b1;
        character_next = ira_pkg::CHAR_MINUS;
      end
      ira_pkg::ST_EMIT: begin
        ctl.op      = ira_pkg::OP_SHIFT;
        strobe_next = !skip;
        last_next   = (digits_left == CW'(1));
      end
      default: begin
        ctl.op = ira_pkg::OP_HOLD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ira_pkg::ST_IDLE;
      mode         <= ira_pkg::KIND_SDEC;
      sign_pending <= 1'b0;
      seen         <= 1'b0;
      digits_left  <= '0;
      bit_count    <= '0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      case (state)
        ira_pkg::ST_IDLE: begin
          if (take) begin
            mode         <= kind;
            sign_pending <= negative;
            seen         <= 1'b0;
            digits_left  <= load_digits;
            bit_count    <= CW'(VALUE_BITS);
          end
        end
        ira_pkg::ST_DABBLE: begin
          bit_count <= bit_count - CW'(1);
        end
        ira_pkg::ST_SIGN: begin
          sign_pending <= 1'b0;
        end
        ira_pkg::ST_EMIT: begin
          digits_left <= digits_left - CW'(1);
          if (!skip) begin
            seen <= 1'b1;
          end
        end
        default: begin
          seen <= seen;
        end
      endcase
    end
  end

  // Output payload; qualified by strobe, so no reset.
  always_ff @(posedge clk) begin
    character <= character_next;
    last      <= last_next;
  end

  // The final character of a run shows only once the sequencer is free again.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("last character shown while still busy");

  // A character that is not the last one means more of the run is still coming.
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final character shown with the sequencer idle");

  // A decimal transfer first runs the BCD loop and shows nothing in the next cycle.
  a_dec_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == ira_pkg::KIND_SDEC || kind == ira_pkg::KIND_UDEC)
    |=> busy && !strobe)
    else $error("decimal operand did not enter conversion");

  // Digit positions remain whenever digits are being emitted.
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == ira_pkg::ST_EMIT |-> digits_left != '0)
    else $error("emitting with no digit positions left");

endmodule

`default_nettype wire

[rtl/ira_digit_unit.sv]
// Shared digit unit: shift-and-add-3 binary-to-BCD step and left-aligned digit shifter.
// Depends on ira_pkg (unit_ctl_t, op_t, radix_t).
`default_nettype none

module ira_digit_unit #(
  parameter int VALUE_BITS = 32,
  parameter int WORK_BITS  = 40
) (
  input  wire logic                  clk,
  input  wire ira_pkg::unit_ctl_t    ctl,
  input  wire logic [VALUE_BITS-1:0] magnitude,
  output logic      [3:0]            digit
);

  localparam int NDIG       = WORK_BITS / 4;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int SH_BIN     = WORK_BITS - VALUE_BITS;
  localparam int SH_OCT     = WORK_BITS - 3 * OCT_DIGITS;
  localparam int SH_HEX     = WORK_BITS - 4 * HEX_DIGITS;

  logic [WORK_BITS-1:0]  work;
  logic [VALUE_BITS-1:0] bits;
  logic [WORK_BITS-1:0]  work_ext;
  logic [WORK_BITS-1:0]  bcd_adj;

  assign work_ext = WORK_BITS'(magnitude);

  // Add 3 to every BCD nibble of 5 or more before the shift.
  always_comb begin
    logic [3:0] nib;
    nib     = 4'd0;
    bcd_adj = work;
    for (int i = 0; i < NDIG; i++) begin
      nib = work[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      ira_pkg::OP_LOAD: begin
        bits <= magnitude;
        case (ctl.radix)
          ira_pkg::RAD_BIN: work <= work_ext << SH_BIN;
          ira_pkg::RAD_OCT: work <= work_ext << SH_OCT;
          ira_pkg::RAD_HEX: work <= work_ext << SH_HEX;
          default:          work <= '0;
        endcase
      end
      ira_pkg::OP_DABBLE: begin
        work <= {bcd_adj[WORK_BITS-2:0], bits[VALUE_BITS-1]};
        bits <= bits << 1;
      end
      ira_pkg::OP_SHIFT: begin
        case (ctl.radix)
          ira_pkg::RAD_BIN: work <= work << 1;
          ira_pkg::RAD_OCT: work <= work << 3;
          default:          work <= work << 4;
        endcase
      end
      default: begin
        work <= work;
      end
    endcase
  end

  // Present the top digit of the left-aligned word.
  always_comb begin
    case (ctl.radix)
      ira_pkg::RAD_BIN: digit = {3'b000, work[WORK_BITS-1]};
      ira_pkg::RAD_OCT: digit = {1'b0, work[WORK_BITS-1 -: 3]};
      default:          digit = work[WORK_BITS-1 -: 4];
    endcase
  end

endmodule

`default_nettype wire

[bench/ira_text_checker.sv]
// Checker for the integer-to-ASCII converter: watches both channels and predicts each run of text.
// Compares every strobed character with the oldest expected one.
// Depends on ira_pkg.
`default_nettype none

module ira_text_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [31:0] value,
  input  wire logic [2:0]  kind,
  input  wire logic        strobe,
  input  wire logic [7:0]  character,
  input  wire logic        last,
  output int               failures,
  output int               pending,
  output int               chars_checked
);

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] LETTER_UPPER = 8'h41;
  localparam logic [7:0] LETTER_LOWER = 8'h61;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } text_char_t;

  text_char_t expected_chars [$];
  text_char_t want;

  initial begin
    failures = 0;
    pending = 0;
    chars_checked = 0;
  end

  // Append the text of one operand to the expected characters.
  function automatic void render_operand(input logic [31:0] v, input logic [2:0] k);
    logic [31:0] mag;
    logic [7:0] rev [32];
    logic [7:0] alpha;
    int unsigned base;
    int unsigned d;
    int nd;
    bit neg;
    mag = v;
    alpha = LETTER_UPPER;
    neg = 1'b0;
    nd = 0;
    case (k)
      ira_pkg::KIND_SDEC: begin
        base = 10;
        neg = v[31];
        if (neg) mag = 32'd0 - v;
      end
      ira_pkg::KIND_UDEC: base = 10;
      ira_pkg::KIND_BIN:  base = 2;
      ira_pkg::KIND_OCT:  base = 8;
      ira_pkg::KIND_HEXL: begin
        base = 16;
        alpha = LETTER_LOWER;
      end
      ira_pkg::KIND_HEXU: base = 16;
      default:   return;
    endcase
    do begin
      d = mag % base;
      rev[nd] = (d < 10) ? 8'(CHAR_ZERO + d) : 8'(alpha + d - 10);
      nd++;
      mag = mag / base;
    end while (mag != 0);
    if (neg) expected_chars.push_back('{ch: ira_pkg::CHAR_MINUS, lst: 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      expected_chars.push_back('{ch: rev[i], lst: (i == 0)});
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          note_failure($sformatf("unexpected character %02h last=%0b", character, last));
        end else begin
          want = expected_chars.pop_front();
          if (want.ch !== character || want.lst !== last)
            note_failure($sformatf("character %02h last=%0b, expected %02h last=%0b",
                                   character, last, want.ch, want.lst));
        end
      end
      if (start && !busy) render_operand(value, kind);
    end
    pending <= expected_chars.size();
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Top of the bench for the integer-to-ASCII converter: clock, reset, operand stimulus, verdict.
// Depends on ira_pkg, integer_radix_to_ascii and ira_text_checker.
`default_nettype none

module testbench;

  // Kinds that the block ignores, giving no output.
  localparam logic [2:0] KIND_UNUSED6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED7 = 3'd7;

  localparam int RANDOM_OPERANDS = 470;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] value = '0;
  logic [2:0]  kind = ira_pkg::KIND_SDEC;
  logic        busy;
  logic        strobe;
  logic [7:0]  character;
  logic        last;

  int failures;
  int pending;
  int chars_checked;
  int kind_count [8];
  int sent;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  integer_radix_to_ascii #(.VALUE_BITS(32)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .value(value),
    .kind(kind),
    .busy(busy),
    .strobe(strobe),
    .character(character),
    .last(last)
  );

  ira_text_checker text_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .kind(kind),
    .strobe(strobe),
    .character(character),
    .last(last),
    .failures(failures),
    .pending(pending),
    .chars_checked(chars_checked)
  );

  // Present one operand and hold it until the block takes it. Start stays high
  // after the transfer when no gap follows, so back-to-back operands never see
  // start dropped and raised in the same step.
  task automatic send(input logic [31:0] v, input logic [2:0] k, input int gap);
    start <= 1'b1;
    value <= v;
    kind <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    kind_count[k]++;
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every expected character has arrived.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly short gaps, a few long enough to span a whole decimal run.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 45);
    return $urandom_range(46, 120);
  endfunction

  // Spread operands over every digit count, sign and bit pattern.
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    logic [31:0] p;
    sel = $urandom_range(0, 9);
    p = 32'd1;
    case (sel)
      0, 1, 2, 3: return $urandom;
      4:          return $urandom_range(0, 20);
      5:          return 32'd0 - $urandom_range(1, 1000);
      6: begin
        // land on and next to a power of ten
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      7:          return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      8:          return $urandom >> $urandom_range(0, 31);
      default:    return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                              : 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [2:0] pick_kind();
    if ($urandom_range(0, 99) < 4) return $urandom_range(0, 1) ? KIND_UNUSED6 : KIND_UNUSED7;
    return 3'($urandom_range(ira_pkg::KIND_SDEC, ira_pkg::KIND_HEXU));
  endfunction

  initial begin
    int made;
    logic [2:0] k;
    made = 0;
    sent = 0;
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero and all ones in every kind, sign edges, digit boundaries,
    // letters in both cases, and the two ignored kinds.
    for (int i = ira_pkg::KIND_SDEC; i <= ira_pkg::KIND_HEXU; i++)
      send(32'd0, 3'(i), pick_gap());
    for (int i = ira_pkg::KIND_SDEC; i <= ira_pkg::KIND_HEXU; i++)
      send(32'hFFFF_FFFF, 3'(i), 0);
    send(32'h8000_0000, ira_pkg::KIND_SDEC, 0);
    send(32'h7FFF_FFFF, ira_pkg::KIND_SDEC, 3);
    send(32'h8000_0000, ira_pkg::KIND_UDEC, 0);
    send(32'hFFFF_FFF6, ira_pkg::KIND_SDEC, 1);
    send(32'd1, ira_pkg::KIND_SDEC, 0);
    send(32'd10, ira_pkg::KIND_UDEC, 0);
    send(32'd1, ira_pkg::KIND_BIN, 2);
    send(32'h0A0B_CDEF, ira_pkg::KIND_HEXL, 0);
    send(32'h0A0B_CDEF, ira_pkg::KIND_HEXU, 0);
    send(32'h1234_5678, KIND_UNUSED6, 0);
    send(32'hFFFF_FFFF, KIND_UNUSED7, 0);
    send(32'd7, ira_pkg::KIND_OCT, 0);
    drain();

    // Random: stretches of back-to-back operands between stretches with gaps,
    // and a full drain now and then.
    while (made < RANDOM_OPERANDS) begin
      k = pick_kind();
      send(pick_value(), k, (made % 100 < 25) ? 0 : pick_gap());
      if (k != KIND_UNUSED6 && k != KIND_UNUSED7) begin
        made++;
        if (made % 97 == 0) drain();
      end
    end

    // Finish: let the last run out, then allow for any trailing latency.
    drain();
    repeat (60) @(posedge clk);
    $display("Summary: %0d operands sent (sdec %0d, udec %0d, bin %0d, oct %0d, hex %0d/%0d)",
             sent, kind_count[ira_pkg::KIND_SDEC], kind_count[ira_pkg::KIND_UDEC],
             kind_count[ira_pkg::KIND_BIN], kind_count[ira_pkg::KIND_OCT],
             kind_count[ira_pkg::KIND_HEXL], kind_count[ira_pkg::KIND_HEXU]);
    $display("Summary: %0d operands of unused kinds, %0d characters checked",
             kind_count[KIND_UNUSED6] + kind_count[KIND_UNUSED7], chars_checked);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #12_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
